// ===== src/dpfa_pkg.sv =====
// Shared types, constants and neighbor helpers of the ring fork arbiter.
`timescale 1ns / 1ps

package dpfa_pkg;

    localparam int MAX_MEMBERS_DEF = 8;
    localparam int RING_SIZE_W     = 4;
    localparam int MEMBER_W        = 3;
    localparam int IDX_W           = RING_SIZE_W;   // neighbor index, below ring size
    localparam int ST_W            = 2;

    localparam logic [RING_SIZE_W-1:0] RING_SIZE_RESET = 4'd5;

    // member state codes
    localparam logic [ST_W-1:0] ST_THINKING = 2'd0;
    localparam logic [ST_W-1:0] ST_HUNGRY   = 2'd1;
    localparam logic [ST_W-1:0] ST_EATING   = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic accept;       // latch the incoming request
        logic write_self;   // write hungry/thinking for the requester
        logic issue_t;      // pick the tested member, read it
        logic issue_l;      // capture tested state, read its left neighbor
        logic issue_r;      // capture left state, read the tested member's right neighbor
        logic decide;       // right state on read port, grant test
        logic phase;        // 0: first test, 1: second test of a release
        logic load_out;     // move result into the output register
    } dpfa_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic bad;          // member not below effective ring size
        logic kind;         // 1: release
        logic out_free;     // output register can take a result
    } dpfa_status_t;

    function automatic logic [IDX_W-1:0] nbr_left(input logic [IDX_W-1:0] idx,
                                                  input logic [IDX_W-1:0] n);
        return (idx == '0) ? n - IDX_W'(1) : idx - IDX_W'(1);
    endfunction

    function automatic logic [IDX_W-1:0] nbr_right(input logic [IDX_W-1:0] idx,
                                                   input logic [IDX_W-1:0] n);
        logic [IDX_W-1:0] inc;
        inc = idx + IDX_W'(1);
        return (inc == n) ? '0 : inc;
    endfunction

endpackage

// ===== src/dpfa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module dpfa_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== src/dpfa_datapath.sv =====
// Datapath: ring size register, state memory, neighbor math, grant test, output register.
`timescale 1ns / 1ps

module dpfa_datapath #(
    parameter int MAX_MEMBERS = dpfa_pkg::MAX_MEMBERS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [dpfa_pkg::RING_SIZE_W-1:0] cfg_wr_data,
    input  logic                             in_kind,
    input  logic [dpfa_pkg::MEMBER_W-1:0]    in_member,
    input  dpfa_pkg::dpfa_cmd_t              cmd,
    output dpfa_pkg::dpfa_status_t           sts,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,
    output logic [0:0]                       m_tuser
);

    import dpfa_pkg::*;

    localparam int AW   = $clog2(MAX_MEMBERS);
    localparam int XW   = (AW > IDX_W) ? AW : IDX_W;
    localparam int CW   = $clog2(MAX_MEMBERS + 1);
    localparam int CMPW = (CW > RING_SIZE_W) ? CW : RING_SIZE_W;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [XW-1:0] wide;
        wide = XW'(idx);
        return wide[AW-1:0];
    endfunction

    logic [RING_SIZE_W-1:0] ring_size_reg;
    logic                   kind_reg;
    logic [MEMBER_W-1:0]    member_reg;
    logic [IDX_W-1:0]       t_reg;
    logic [ST_W-1:0]        st_reg, sl_reg;
    logic                   fgv_reg, sgv_reg;
    logic [MEMBER_W-1:0]    fg_reg, sg_reg;
    logic                   m_tvalid_reg;
    logic [7:0]             m_tdata_reg;
    logic                   m_tuser_reg;
    logic [MAX_MEMBERS-1:0] valid_reg;
    logic                   rd_vld_reg;

    logic [IDX_W-1:0] n, m_idx, left_m, right_m, target, left_t, right_t;
    logic [AW-1:0]    rd_addr, wr_addr;
    logic [ST_W-1:0]  wr_data, rd_raw, rd_state;
    logic             wr_en, grant;

    // effective ring size saturates at the memory depth
    always_comb begin
        if (CMPW'(ring_size_reg) > CMPW'(MAX_MEMBERS)) begin
            n = RING_SIZE_W'(MAX_MEMBERS);
        end else begin
            n = ring_size_reg;
        end
    end

    assign m_idx   = IDX_W'(member_reg);
    assign left_m  = nbr_left(m_idx, n);
    assign right_m = nbr_right(m_idx, n);
    assign target  = cmd.phase ? right_m : (kind_reg ? left_m : m_idx);
    assign left_t  = nbr_left(t_reg, n);
    assign right_t = nbr_right(t_reg, n);

    always_comb begin
        rd_addr = '0;
        if (cmd.issue_t) begin
            rd_addr = to_addr(target);
        end else if (cmd.issue_l) begin
            rd_addr = to_addr(left_t);
        end else if (cmd.issue_r) begin
            rd_addr = to_addr(right_t);
        end
    end

    // never-written entries read as thinking
    assign rd_state = rd_vld_reg ? rd_raw : ST_THINKING;
    assign grant    = (st_reg == ST_HUNGRY) && (sl_reg != ST_EATING)
                      && (rd_state != ST_EATING);

    assign wr_en   = cmd.write_self || (cmd.decide && grant);
    assign wr_addr = cmd.write_self ? to_addr(m_idx) : to_addr(t_reg);
    assign wr_data = cmd.write_self ? (kind_reg ? ST_THINKING : ST_HUNGRY) : ST_EATING;

    dpfa_ram #(
        .WIDTH (ST_W),
        .DEPTH (MAX_MEMBERS)
    ) u_state_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_raw)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_size_reg <= RING_SIZE_RESET;
            valid_reg     <= '0;
            rd_vld_reg    <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                ring_size_reg <= cfg_wr_data;
            end
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= valid_reg[rd_addr];
            if (cmd.load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg   <= in_kind;
            member_reg <= in_member;
            fgv_reg    <= 1'b0;
            fg_reg     <= '0;
            sgv_reg    <= 1'b0;
            sg_reg     <= '0;
        end
        if (cmd.issue_t) begin
            t_reg <= target;
        end
        if (cmd.issue_l) begin
            st_reg <= rd_state;
        end
        if (cmd.issue_r) begin
            sl_reg <= rd_state;
        end
        if (cmd.decide) begin
            if (cmd.phase) begin
                sgv_reg <= grant;
                sg_reg  <= t_reg[MEMBER_W-1:0];
            end else begin
                fgv_reg <= grant;
                fg_reg  <= t_reg[MEMBER_W-1:0];
            end
        end
        if (cmd.load_out) begin
            m_tdata_reg <= {sg_reg, sgv_reg, fg_reg, fgv_reg};
            m_tuser_reg <= sts.bad;
        end
    end

    assign sts.bad      = (m_idx >= n);
    assign sts.kind     = kind_reg;
    assign sts.out_free = !m_tvalid_reg || m_tready;

    assign m_tvalid   = m_tvalid_reg;
    assign m_tdata    = m_tdata_reg;
    assign m_tuser[0] = m_tuser_reg;

endmodule

// ===== src/dpfa_ctrl.sv =====
// Controller: sequences the self update and up to two grant tests per request.
`timescale 1ns / 1ps

module dpfa_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  dpfa_pkg::dpfa_status_t sts,
    output dpfa_pkg::dpfa_cmd_t    cmd
);

    import dpfa_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SELF,
        S_RD_T,
        S_RD_L,
        S_RD_R,
        S_DECIDE,
        S_FINISH
    } state_t;

    state_t state_reg, state_next;
    logic   phase_reg, phase_next;

    always_comb begin
        state_next = state_reg;
        phase_next = phase_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    state_next = S_SELF;
                    phase_next = 1'b0;
                end
            end
            S_SELF: begin
                state_next = sts.bad ? S_FINISH : S_RD_T;
            end
            S_RD_T:   state_next = S_RD_L;
            S_RD_L:   state_next = S_RD_R;
            S_RD_R:   state_next = S_DECIDE;
            S_DECIDE: begin
                if (sts.kind && !phase_reg) begin
                    phase_next = 1'b1;
                    state_next = S_RD_T;
                end else begin
                    state_next = S_FINISH;
                end
            end
            S_FINISH: begin
                if (sts.out_free) begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            phase_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            phase_reg <= phase_next;
        end
    end

    assign s_tready       = (state_reg == S_IDLE);
    assign cmd.accept     = (state_reg == S_IDLE) && s_tvalid;
    assign cmd.write_self = (state_reg == S_SELF) && !sts.bad;
    assign cmd.issue_t    = (state_reg == S_RD_T);
    assign cmd.issue_l    = (state_reg == S_RD_L);
    assign cmd.issue_r    = (state_reg == S_RD_R);
    assign cmd.decide     = (state_reg == S_DECIDE);
    assign cmd.phase      = phase_reg;
    assign cmd.load_out   = (state_reg == S_FINISH) && sts.out_free;

endmodule

// ===== src/dining_philosophers_fork_arbiter.sv =====
// Top level of the ring fork arbiter: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Each request: self update, one grant test (hungry) or two (release), none for a
// bad member, then the finish step, which loads the output register once it is
// free. One request is in flight at a time; each grant test makes three reads
// through the one registered read port of the state RAM. A pending output result
// does not stop the next request from being taken. Synchronous active-low reset:
// ring size 5, every member thinking (per-entry valid bits), no clearing pass.

module dining_philosophers_fork_arbiter #(
    parameter int MAX_MEMBERS = dpfa_pkg::MAX_MEMBERS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // ring size register
    input  logic                             cfg_wr_en,
    input  logic [dpfa_pkg::RING_SIZE_W-1:0] cfg_wr_data,
    // event request
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [7:0]                       s_tdata,   // [2:0] member, [7:3] zero
    input  logic [0:0]                       s_tuser,   // [0] kind: 0 hungry, 1 release
    // grant result
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [7:0]                       m_tdata,   // [0] first_grant_valid,
                                                        // [3:1] first_grant,
                                                        // [4] second_grant_valid,
                                                        // [7:5] second_grant
    output logic [0:0]                       m_tuser    // [0] bad_member
);

    import dpfa_pkg::*;

    dpfa_cmd_t    cmd;
    dpfa_status_t sts;

    // controller: walks self update, then one or two neighbor tests
    dpfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: state RAM, neighbor indices, grant compare, output register
    dpfa_datapath #(
        .MAX_MEMBERS (MAX_MEMBERS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_kind     (s_tuser[0]),
        .in_member   (s_tdata[MEMBER_W-1:0]),
        .cmd         (cmd),
        .sts         (sts),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

    // one request at a time: ready drops right after a request is taken
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request taken while another is in flight");

    // a result is only loaded as the controller returns to idle
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> s_tready)
        else $error("result loaded outside the finish step");

    // an ignored event carries no grants
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0]) |-> (m_tdata == 8'h00))
        else $error("bad member result carries grant data");

endmodule
